/* design/polyphonic_oscillator_mixer_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the polyphonic oscillator mixer
// Implication checks on the rising clock edge, held off while reset is low.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_OSCILLATOR_MIXER_DEFINES_SVH
`define POLYPHONIC_OSCILLATOR_MIXER_DEFINES_SVH

// same-cycle implication
`define POM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define POM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pom_pkg.sv */
// ----------------------------------------------------------------------------
// pom_pkg
// Shared types, constants and table functions of the oscillator mixer.
// ----------------------------------------------------------------------------
package pom_pkg;

    localparam int VOICES     = 5;
    localparam int SINE_DEPTH = 1024;   // power of two

    localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
    localparam int VIDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W      = $clog2(VOICES + 1);

    localparam int KIND_W     = 2;
    localparam int KEY_W      = 8;
    localparam int STEP_W     = 31;
    localparam int PHASE_W    = 32;
    localparam int MODE_W     = 3;
    localparam int VOL_W      = 15;
    localparam int DUTY_W     = 16;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int VAL_W = 17;                       // one voice, Q1.15 with +1.0
    localparam int MIX_W = VAL_W + $clog2(VOICES);   // sum of all voices
    localparam int INV_W = 17;                       // 1/sqrt(n) in Q16
    localparam int P1_W  = MIX_W + INV_W;
    localparam int P2_W  = P1_W + VOL_W;
    localparam int Q_W   = P2_W - 14;                // quotient by 32767

    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY      = 2'd2;

    localparam logic [MODE_W-1:0] WAVE_SINE     = 3'd0;
    localparam logic [MODE_W-1:0] WAVE_SQUARE   = 3'd1;
    localparam logic [MODE_W-1:0] WAVE_SAW      = 3'd2;
    localparam logic [MODE_W-1:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [MODE_W-1:0] WAVE_PULSE    = 3'd4;

    localparam logic [MODE_W-1:0] WAVE_MODE_RESET = 3'd0;
    localparam logic [VOL_W-1:0]  VOLUME_RESET    = 15'd28000;
    localparam logic [DUTY_W-1:0] DUTY_RESET      = 16'd19661;

    localparam logic signed [VAL_W-1:0] VAL_POS = 17'sh08000;   // +1.0
    localparam logic signed [VAL_W-1:0] VAL_NEG = 17'sh18000;   // -1.0

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic               on;
        logic [KEY_W-1:0]   key;
        logic [STEP_W-1:0]  step;
        logic [PHASE_W-1:0] phase;
    } voice_t;

    typedef struct packed {
        logic shift;
        logic write;
    } cell_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } scale_stat_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_SCAN,
        T_COMMIT,
        T_DRAIN,
        T_SCALE
    } top_state_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MUL1,
        SC_MUL2,
        SC_FOLD,
        SC_FIX
    } scale_state_t;

    typedef logic signed [VAL_W-1:0] sine_rom_t [SINE_DEPTH];

    // quarter-wave Taylor polynomial, Q30, rounded to Q1.15
    function automatic logic signed [VAL_W-1:0] quarter_sine(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        x  = (HALF_PI_Q30 * r) / SINE_DEPTH;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        v  = (s * 32768 + (Q30_ONE >> 1)) >> 30;
        return VAL_W'(v);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t                 rom;
        longint unsigned           n;
        longint unsigned           quad;
        longint unsigned           r;
        logic signed [VAL_W-1:0]   v;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            n    = 4 * i;
            quad = n / SINE_DEPTH;
            r    = n % SINE_DEPTH;
            v    = quad[0] ? quarter_sine(SINE_DEPTH - r) : quarter_sine(r);
            rom[i] = quad[1] ? -v : v;
        end
        return rom;
    endfunction

    // round(65536 / sqrt(n))
    function automatic logic [INV_W-1:0] inv_sqrt_q16(input logic [CNT_W-1:0] n);
        logic [4:0]       idx;
        logic [INV_W-1:0] v;
        idx = 5'(n);
        case (idx)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd65536;
            5'd2:    v = 17'd46341;
            5'd3:    v = 17'd37837;
            5'd4:    v = 17'd32768;
            5'd5:    v = 17'd29309;
            5'd6:    v = 17'd26755;
            5'd7:    v = 17'd24770;
            5'd8:    v = 17'd23170;
            5'd9:    v = 17'd21845;
            5'd10:   v = 17'd20724;
            5'd11:   v = 17'd19760;
            5'd12:   v = 17'd18919;
            5'd13:   v = 17'd18176;
            5'd14:   v = 17'd17515;
            5'd15:   v = 17'd16921;
            default: v = 17'd16384;
        endcase
        return v;
    endfunction

endpackage

/* design/pom_cell.sv */
// ----------------------------------------------------------------------------
// pom_cell
// One voice slot of the voice ring: shifts to its neighbor or takes a write.
// ----------------------------------------------------------------------------
module pom_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  pom_pkg::cell_ctrl_t ctrl,
    input  pom_pkg::voice_t    din,
    input  pom_pkg::voice_t    wdata,
    output pom_pkg::voice_t    q
);

    pom_pkg::voice_t voice_reg;
    pom_pkg::voice_t voice_next;

    always_comb
    begin
        voice_next = voice_reg;
        if (ctrl.write)
        begin
            voice_next = wdata;
        end
        else if (ctrl.shift)
        begin
            voice_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_reg <= '0;
        end
        else
        begin
            voice_reg <= voice_next;
        end
    end

    assign q = voice_reg;

endmodule

/* design/pom_wave.sv */
// ----------------------------------------------------------------------------
// pom_wave
// Waveform generator for the voice at the ring tap; its values are registered.
// ----------------------------------------------------------------------------
module pom_wave (
    input  logic                               clk,
    input  logic                               act,
    input  logic [pom_pkg::PHASE_W-1:0]        phase,
    input  logic [pom_pkg::MODE_W-1:0]         mode,
    input  logic [pom_pkg::DUTY_W-1:0]         duty,
    output logic                               val_valid,
    output logic signed [pom_pkg::VAL_W-1:0]   val
);

    localparam pom_pkg::sine_rom_t SINE_ROM = pom_pkg::build_sine_rom();

    logic signed [pom_pkg::VAL_W-1:0] rom_q_reg;
    logic signed [pom_pkg::VAL_W-1:0] alt_reg;
    logic signed [pom_pkg::VAL_W-1:0] alt_next;
    logic                             sine_sel_reg;
    logic                             act_reg;

    logic signed [pom_pkg::VAL_W-1:0] saw;
    logic        [pom_pkg::VAL_W-1:0] saw_abs;
    logic        [pom_pkg::VAL_W:0]   tri_wide;

    assign saw     = pom_pkg::VAL_W'($signed(phase[pom_pkg::PHASE_W-1 -: 16]));
    assign saw_abs = saw[pom_pkg::VAL_W-1] ? pom_pkg::VAL_W'(-saw) : pom_pkg::VAL_W'(saw);
    assign tri_wide = {saw_abs, 1'b0} - (pom_pkg::VAL_W+1)'(32768);

    always_comb
    begin
        case (mode)
            pom_pkg::WAVE_SQUARE:
                alt_next = ((phase != '0) && !phase[pom_pkg::PHASE_W-1]) ?
                           pom_pkg::VAL_POS : pom_pkg::VAL_NEG;
            pom_pkg::WAVE_SAW:
                alt_next = saw;
            pom_pkg::WAVE_TRIANGLE:
                alt_next = $signed(tri_wide[pom_pkg::VAL_W-1:0]);
            pom_pkg::WAVE_PULSE:
                alt_next = (phase < {duty, 16'h0000}) ? pom_pkg::VAL_POS : pom_pkg::VAL_NEG;
            default:
                alt_next = '0;
        endcase
    end

    // sine table read is registered
    always_ff @(posedge clk)
    begin
        rom_q_reg    <= SINE_ROM[phase[pom_pkg::PHASE_W-1 -: pom_pkg::SINE_IDX_W]];
        alt_reg      <= alt_next;
        sine_sel_reg <= (mode == pom_pkg::WAVE_SINE);
        act_reg      <= act;
    end

    assign val_valid = act_reg;
    assign val       = !act_reg ? '0 : (sine_sel_reg ? rom_q_reg : alt_reg);

endmodule

/* design/pom_scale.sv */
// ----------------------------------------------------------------------------
// pom_scale
// Mix scaling: 1/sqrt(n), volume/32767, clamp, Q1.15 conversion.
// ----------------------------------------------------------------------------
module pom_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              take,
    input  logic signed [pom_pkg::MIX_W-1:0]  mix,
    input  logic [pom_pkg::CNT_W-1:0]         count,
    input  logic [pom_pkg::VOL_W-1:0]         volume,
    output pom_pkg::scale_stat_t              stat,
    output logic signed [pom_pkg::OUT_W-1:0]  sample
);

    localparam int P2_W = pom_pkg::P2_W;
    localparam int Q_W  = pom_pkg::Q_W;

    pom_pkg::scale_state_t state_reg;
    pom_pkg::scale_state_t state_next;

    logic                          neg_reg;
    logic [pom_pkg::MIX_W-1:0]     mag_reg;
    logic [pom_pkg::INV_W-1:0]     inv_reg;
    logic [pom_pkg::VOL_W-1:0]     vol_reg;
    logic [pom_pkg::P1_W-1:0]      p1_reg;
    logic [P2_W-1:0]               rem_reg;
    logic [Q_W-1:0]                quo_reg;

    logic                          fold_more;
    logic [P2_W-1:0]               rem_hi;
    logic [1:0]                    corr;
    logic [31:0]                   sat;
    logic [46:0]                   scaled;
    logic [pom_pkg::OUT_W-1:0]     mag16;

    // x / 32767 by folding: 32768*h + l == 32767*h + (h + l)
    assign fold_more = (rem_reg[P2_W-1:16] != '0);
    assign rem_hi    = rem_reg >> 15;
    assign corr      = (rem_reg[15:0] >= 16'd65534) ? 2'd2 :
                       (rem_reg[15:0] >= 16'd32767) ? 2'd1 : 2'd0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pom_pkg::SC_IDLE: if (start) state_next = pom_pkg::SC_MUL1;
            pom_pkg::SC_MUL1: state_next = pom_pkg::SC_MUL2;
            pom_pkg::SC_MUL2: state_next = pom_pkg::SC_FOLD;
            pom_pkg::SC_FOLD: if (!fold_more) state_next = pom_pkg::SC_FIX;
            pom_pkg::SC_FIX:  if (take) state_next = pom_pkg::SC_IDLE;
            default:          state_next = pom_pkg::SC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pom_pkg::SC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            pom_pkg::SC_IDLE:
            begin
                neg_reg <= mix[pom_pkg::MIX_W-1];
                mag_reg <= mix[pom_pkg::MIX_W-1] ? pom_pkg::MIX_W'(-mix) : pom_pkg::MIX_W'(mix);
                inv_reg <= pom_pkg::inv_sqrt_q16(count);
                vol_reg <= volume;
            end
            pom_pkg::SC_MUL1:
            begin
                p1_reg <= pom_pkg::P1_W'(mag_reg) * pom_pkg::P1_W'(inv_reg);
            end
            pom_pkg::SC_MUL2:
            begin
                rem_reg <= P2_W'(p1_reg) * P2_W'(vol_reg);
                quo_reg <= '0;
            end
            pom_pkg::SC_FOLD:
            begin
                if (fold_more)
                begin
                    rem_reg <= rem_hi + P2_W'(rem_reg[14:0]);
                    quo_reg <= quo_reg + Q_W'(rem_hi);
                end
                else
                begin
                    quo_reg <= quo_reg + Q_W'(corr);
                end
            end
            default:
            begin
            end
        endcase
    end

    // clamp to 1.0 (2^31), then times 32767 and down by 31
    assign sat    = (quo_reg > Q_W'(64'h8000_0000)) ? 32'h8000_0000 : quo_reg[31:0];
    assign scaled = {sat, 15'b0} - {15'b0, sat};
    assign mag16  = scaled[46:31];

    always_comb
    begin
        stat.busy = (state_reg != pom_pkg::SC_IDLE);
        stat.done = (state_reg == pom_pkg::SC_FIX);
        sample    = neg_reg ? $signed(-mag16) : $signed(mag16);
    end

endmodule

/* design/polyphonic_oscillator_mixer.sv */
// ----------------------------------------------------------------------------
// polyphonic_oscillator_mixer
// Five-voice phase-accumulator synth with key press/release and sample mixing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request: kind 0 press,
//   1 release, 2 sample tick; key_code and phase_step go with it. Only a
//   tick produces a result, on the out_valid/out_ready channel (sample).
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data):
//   index 0 wave_mode, 1 volume, 2 duty; other indexes are dropped.
//   Write it only while the block is idle.
//   Voices sit in a ring of cells that rotates one voice per cycle past a
//   tap during a scan, so a press, release or tick passes every voice by
//   the tap once; an undefined kind is taken and dropped with no scan.
//   Press: accept, scan, commit, then the next request. Release: accept, scan.
//   Tick: accept, scan, table read, scale start, multiply by 1/sqrt(n),
//   multiply by volume, fold steps of the divide by 32767, finish; the
//   sample is loaded at the finish step and the next request is taken after it.
//   Results sit in an output register; a further request is taken while it
//   waits, and a later tick holds at its finish step until that is taken.
//   Reset (rst_n low, async) frees all voices and loads the register reset
//   values: sine wave, volume 28000, duty 19661.
// ----------------------------------------------------------------------------
`include "polyphonic_oscillator_mixer_defines.svh"

module polyphonic_oscillator_mixer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [pom_pkg::KIND_W-1:0]            kind,
    input  logic [pom_pkg::KEY_W-1:0]             key_code,
    input  logic [pom_pkg::STEP_W-1:0]            phase_step,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pom_pkg::OUT_W-1:0]      sample,
    input  logic                                  cfg_we,
    input  logic [pom_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pom_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int VOICES = pom_pkg::VOICES;
    localparam int VIDX_W = pom_pkg::VIDX_W;

    // control state
    pom_pkg::top_state_t state_reg;
    pom_pkg::top_state_t state_next;

    // config registers
    logic [pom_pkg::MODE_W-1:0] wave_mode_reg;
    logic [pom_pkg::MODE_W-1:0] wave_mode_next;
    logic [pom_pkg::VOL_W-1:0]  volume_reg;
    logic [pom_pkg::VOL_W-1:0]  volume_next;
    logic [pom_pkg::DUTY_W-1:0] duty_reg;
    logic [pom_pkg::DUTY_W-1:0] duty_next;

    // latched request and scan bookkeeping
    logic [pom_pkg::KIND_W-1:0] kind_reg;
    logic [pom_pkg::KIND_W-1:0] kind_next;
    logic [pom_pkg::KEY_W-1:0]  key_reg;
    logic [pom_pkg::KEY_W-1:0]  key_next;
    logic [pom_pkg::STEP_W-1:0] step_reg;
    logic [pom_pkg::STEP_W-1:0] step_next;
    logic [VIDX_W-1:0]          scan_k_reg;
    logic [VIDX_W-1:0]          scan_k_next;
    logic                       dup_reg;
    logic                       dup_next;
    logic                       free_found_reg;
    logic                       free_found_next;
    logic [VIDX_W-1:0]          free_idx_reg;
    logic [VIDX_W-1:0]          free_idx_next;
    logic                       rel_done_reg;
    logic                       rel_done_next;
    logic signed [pom_pkg::MIX_W-1:0] mix_reg;
    logic signed [pom_pkg::MIX_W-1:0] mix_next;
    logic [pom_pkg::CNT_W-1:0]  cnt_reg;
    logic [pom_pkg::CNT_W-1:0]  cnt_next;

    // output register
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [pom_pkg::OUT_W-1:0]  sample_reg;
    logic signed [pom_pkg::OUT_W-1:0]  sample_next;

    // handshake and sequencing
    logic accept;
    logic real_kind;
    logic scan_last;
    logic shift_en;
    logic commit_en;
    logic scale_start;
    logic out_take;
    logic load_out;

    // voice ring
    pom_pkg::voice_t     cell_q    [VOICES];
    pom_pkg::voice_t     cell_din  [VOICES];
    pom_pkg::cell_ctrl_t cell_ctrl [VOICES];
    pom_pkg::voice_t     head;
    pom_pkg::voice_t     tap_fb;
    pom_pkg::voice_t     new_voice;
    logic                hit;
    logic                live;

    // wave and scale units
    logic                              wave_act;
    logic                              wave_valid;
    logic signed [pom_pkg::VAL_W-1:0]  wave_val;
    pom_pkg::scale_stat_t              scale_stat;
    logic signed [pom_pkg::OUT_W-1:0]  scale_sample;

    assign accept    = in_valid && in_ready;
    assign real_kind = (kind == pom_pkg::KIND_PRESS) || (kind == pom_pkg::KIND_RELEASE) ||
                       (kind == pom_pkg::KIND_TICK);
    assign scan_last = (scan_k_reg == VIDX_W'(VOICES - 1));
    assign out_take  = !out_valid_reg || out_ready;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pom_pkg::T_IDLE:
                if (accept && real_kind) state_next = pom_pkg::T_SCAN;
            pom_pkg::T_SCAN:
                if (scan_last)
                begin
                    if (kind_reg == pom_pkg::KIND_PRESS)
                        state_next = pom_pkg::T_COMMIT;
                    else if (kind_reg == pom_pkg::KIND_TICK)
                        state_next = pom_pkg::T_DRAIN;
                    else
                        state_next = pom_pkg::T_IDLE;
                end
            pom_pkg::T_COMMIT:
                state_next = pom_pkg::T_IDLE;
            pom_pkg::T_DRAIN:
                state_next = pom_pkg::T_SCALE;
            pom_pkg::T_SCALE:
                if (scale_stat.done && out_take) state_next = pom_pkg::T_IDLE;
            default:
                state_next = pom_pkg::T_IDLE;
        endcase
    end

    // ---------------- FSM outputs ----------------
    always_comb
    begin
        in_ready    = (state_reg == pom_pkg::T_IDLE);
        shift_en    = (state_reg == pom_pkg::T_SCAN);
        commit_en   = (state_reg == pom_pkg::T_COMMIT) && !dup_reg && free_found_reg;
        scale_start = (state_reg == pom_pkg::T_SCALE) && !scale_stat.busy;
        load_out    = (state_reg == pom_pkg::T_SCALE) && scale_stat.done && out_take;
    end

    // ---------------- ring tap ----------------
    // Voice 0 sits at the tap first; the modified voice re-enters at the far end,
    // so after a full scan every voice is back in its own slot.
    assign head = cell_q[0];
    assign hit  = head.on && (head.key == key_reg);
    assign live = head.on && (head.step != '0);

    always_comb
    begin
        tap_fb = head;
        if ((kind_reg == pom_pkg::KIND_TICK) && live)
        begin
            tap_fb.phase = head.phase + {1'b0, head.step};
        end
        if ((kind_reg == pom_pkg::KIND_RELEASE) && hit && !rel_done_reg)
        begin
            tap_fb = '0;
        end
    end

    always_comb
    begin
        new_voice.on    = 1'b1;
        new_voice.key   = key_reg;
        new_voice.step  = step_reg;
        new_voice.phase = '0;
    end

    for (genvar i = 0; i < VOICES; i++)
    begin : g_cell
        if (i == VOICES - 1)
        begin : g_end
            assign cell_din[i] = tap_fb;
        end
        else
        begin : g_mid
            assign cell_din[i] = cell_q[i+1];
        end

        assign cell_ctrl[i].shift = shift_en;
        assign cell_ctrl[i].write = commit_en && (free_idx_reg == VIDX_W'(i));

        pom_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (cell_ctrl[i]),
            .din   (cell_din[i]),
            .wdata (new_voice),
            .q     (cell_q[i])
        );
    end

    // ---------------- wave generation ----------------
    assign wave_act = shift_en && (kind_reg == pom_pkg::KIND_TICK) && live;

    pom_wave u_wave (
        .clk       (clk),
        .act       (wave_act),
        .phase     (head.phase),
        .mode      (wave_mode_reg),
        .duty      (duty_reg),
        .val_valid (wave_valid),
        .val       (wave_val)
    );

    // ---------------- request datapath ----------------
    always_comb
    begin
        kind_next       = kind_reg;
        key_next        = key_reg;
        step_next       = step_reg;
        scan_k_next     = scan_k_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        rel_done_next   = rel_done_reg;
        mix_next        = mix_reg;
        cnt_next        = cnt_reg;

        if (accept)
        begin
            kind_next       = kind;
            key_next        = key_code;
            step_next       = phase_step;
            scan_k_next     = '0;
            dup_next        = 1'b0;
            free_found_next = 1'b0;
            free_idx_next   = '0;
            rel_done_next   = 1'b0;
            mix_next        = '0;
            cnt_next        = '0;
        end
        else
        begin
            if (shift_en)
            begin
                scan_k_next = scan_k_reg + 1'b1;
                if (hit)
                begin
                    dup_next = 1'b1;
                end
                // first free slot in voice order
                if (!free_found_reg && !head.on)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = scan_k_reg;
                end
                if ((kind_reg == pom_pkg::KIND_RELEASE) && hit)
                begin
                    rel_done_next = 1'b1;
                end
                if (wave_act)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            // values arrive in the cycle after their tap
            if (wave_valid)
            begin
                mix_next = mix_reg + pom_pkg::MIX_W'(wave_val);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        step_reg       <= step_next;
        scan_k_reg     <= scan_k_next;
        dup_reg        <= dup_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        rel_done_reg   <= rel_done_next;
        mix_reg        <= mix_next;
        cnt_reg        <= cnt_next;
        sample_reg     <= sample_next;
    end

    // ---------------- scaling ----------------
    pom_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scale_start),
        .take   (out_take),
        .mix    (mix_reg),
        .count  (cnt_reg),
        .volume (volume_reg),
        .stat   (scale_stat),
        .sample (scale_sample)
    );

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            sample_next    = scale_sample;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // ---------------- configuration ----------------
    always_comb
    begin
        wave_mode_next = wave_mode_reg;
        volume_next    = volume_reg;
        duty_next      = duty_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pom_pkg::REG_WAVE_MODE: wave_mode_next = cfg_data[pom_pkg::MODE_W-1:0];
                pom_pkg::REG_VOLUME:    volume_next    = cfg_data[pom_pkg::VOL_W-1:0];
                pom_pkg::REG_DUTY:      duty_next      = cfg_data[pom_pkg::DUTY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pom_pkg::T_IDLE;
            out_valid_reg <= 1'b0;
            wave_mode_reg <= pom_pkg::WAVE_MODE_RESET;
            volume_reg    <= pom_pkg::VOLUME_RESET;
            duty_reg      <= pom_pkg::DUTY_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            wave_mode_reg <= wave_mode_next;
            volume_reg    <= volume_next;
            duty_reg      <= duty_next;
        end
    end

    // ---------------- assertions ----------------
    `POM_ASSERT_IMPLY(a_idle_scale_free, in_ready, !scale_stat.busy, "request taken while scaling")
    `POM_ASSERT_IMPLY(a_out_from_scale, $rose(out_valid_reg), $past(scale_stat.done), "sample without scale result")
    `POM_ASSERT_NEXT(a_busy_after_req, accept && real_kind, !in_ready, "second request during scan")
    `POM_ASSERT_IMPLY(a_commit_free, commit_en, !cell_q[free_idx_reg].on, "press claims a sounding voice")

endmodule
